// ----- rtl/core/dbtd_pkg.sv -----
// Shared types, constants and the GCR code table for the DSHOT telemetry decoder.
// No dependencies; used by dbtd_div and dshot_bidir_telemetry_decoder_top.
package dbtd_pkg;

  localparam int FRAME_BITS = 21;
  localparam int TOTAL_SAT  = FRAME_BITS + 1;
  localparam int TOTAL_W    = 5;
  localparam int TICKS_W    = 15;
  localparam int PERIOD_W   = 13;
  localparam int TICK_NS    = 100;
  localparam int DIVIDEND_W = 22;
  localparam int QUOT_W     = 22;
  localparam int REM_W      = PERIOD_W;
  localparam int PAYLOAD_W  = 12;
  localparam int CODE_W     = 16;
  localparam int ERPM_W     = 16;
  localparam int CNT_W      = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 13'd2666;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_NONE = 12'hFFF;

  // configuration register addresses
  localparam logic [2:0] ADDR_BIT_PERIOD = 3'd0;

  typedef enum logic [2:0] {
    ST_ERPM      = 3'd0,
    ST_TELEM     = 3'd1,
    ST_BAD_CRC   = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_BAD_START = 3'd4
  } status_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic              busy;
    logic [QUOT_W-1:0] quotient;
  } div_stat_t;

  // GCR 5-bit code to nibble; invalid codes give 0xFF
  function automatic logic [7:0] gcr_decode(input logic [4:0] code);
    logic [7:0] nib;
    unique case (code)
      5'h09:   nib = 8'h09;
      5'h0A:   nib = 8'h0A;
      5'h0B:   nib = 8'h0B;
      5'h0D:   nib = 8'h0D;
      5'h0E:   nib = 8'h0E;
      5'h0F:   nib = 8'h0F;
      5'h12:   nib = 8'h02;
      5'h13:   nib = 8'h03;
      5'h15:   nib = 8'h05;
      5'h16:   nib = 8'h06;
      5'h17:   nib = 8'h07;
      5'h19:   nib = 8'h00;
      5'h1A:   nib = 8'h08;
      5'h1B:   nib = 8'h01;
      5'h1D:   nib = 8'h04;
      5'h1E:   nib = 8'h0C;
      default: nib = 8'hFF;
    endcase
    return nib;
  endfunction

endpackage

// ----- rtl/core/dbtd_div.sv -----
// Restoring divider, one quotient bit per cycle, for run length to bit count.
// Depends on dbtd_pkg.
module dbtd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dbtd_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [dbtd_pkg::PERIOD_W-1:0]    divisor,
  output dbtd_pkg::div_stat_t              stat
);

  localparam int STEP_W = $clog2(dbtd_pkg::QUOT_W + 1);

  logic [STEP_W-1:0]              count;
  logic [dbtd_pkg::REM_W-1:0]     rem;
  logic [dbtd_pkg::QUOT_W-1:0]    quot;
  logic [dbtd_pkg::PERIOD_W-1:0]  dvsr;

  logic [dbtd_pkg::REM_W:0]       trial;
  logic [dbtd_pkg::REM_W+1:0]     diff;
  logic                           ge;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem, quot[dbtd_pkg::QUOT_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvsr};
    ge    = ~diff[dbtd_pkg::REM_W+1];
  end

  // load on start, then shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= STEP_W'(dbtd_pkg::QUOT_W);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dbtd_pkg::QUOT_W'(dividend);
      dvsr <= divisor;
    end else if (count != '0) begin
      rem  <= ge ? diff[dbtd_pkg::REM_W-1:0] : trial[dbtd_pkg::REM_W-1:0];
      quot <= {quot[dbtd_pkg::QUOT_W-2:0], ge};
    end
  end

  assign stat.busy     = (count != '0);
  assign stat.quotient = quot;

endmodule

// ----- rtl/core/dshot_bidir_telemetry_decoder_top.sv -----
// Top level of the bidirectional DSHOT GCR telemetry decoder.
// Depends on dbtd_pkg and dbtd_div.
//
//  channel   dir  handshake          contents
//  s_*       in   tvalid/tready      one measured line run (level, ticks)
//  m_*       out  tvalid/tready      one decoded frame report, status in tuser
//  APB       in   psel/penable       bit_period_ns at address 0
//
// A run with nonzero length is accepted, divided in the restoring divider (one
// quotient bit per cycle), and its bits are then shifted into the frame register.
// A frame end adds a decode state and a report state; the report waits while the
// output register still holds an untaken transfer. s_tready is high only when
// the sequencer is idle. Reset is synchronous and clears the frame and counters.
module dshot_bidir_telemetry_decoder_top #(
  parameter int MAX_RUNS = 42
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [0] run_level, [15:1] run_ticks
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [11:0] raw_payload, [27:12] erpm_period_us,
                                  // [30:28] telem_type, [38:31] telem_value,
                                  // [70:39] frames_seen, [102:71] frames_good
  output logic [2:0]   m_tuser,   // [2:0] status
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IDX_W = $clog2(MAX_RUNS + 1);
  localparam logic [dbtd_pkg::FRAME_BITS-1:0] ONES = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DECODE,
    S_REPORT
  } state_t;

  state_t                            state;
  logic [dbtd_pkg::PERIOD_W-1:0]     bit_period_ns;
  logic [dbtd_pkg::FRAME_BITS-1:0]   bit_shift_reg;
  logic [dbtd_pkg::TOTAL_W-1:0]      bit_total;
  logic [IDX_W-1:0]                  run_index;
  logic                              start_ok;
  logic                              run_level_q;
  logic [dbtd_pkg::CNT_W-1:0]        seen_counter;
  logic [dbtd_pkg::CNT_W-1:0]        good_counter;
  logic [dbtd_pkg::CODE_W-1:0]       code_word;
  dbtd_pkg::status_t                 frame_kind;

  // output register
  dbtd_pkg::status_t                 out_status;
  logic [dbtd_pkg::PAYLOAD_W-1:0]    out_payload;
  logic [dbtd_pkg::ERPM_W-1:0]       out_erpm;
  logic [2:0]                        out_type;
  logic [7:0]                        out_value;
  logic [dbtd_pkg::CNT_W-1:0]        out_seen;
  logic [dbtd_pkg::CNT_W-1:0]        out_good;

  logic                              run_level;
  logic [dbtd_pkg::TICKS_W-1:0]      run_ticks;
  logic                              in_xfer;
  logic                              cfg_wr;
  logic                              start_ok_in;
  logic [dbtd_pkg::PERIOD_W-1:0]     period_eff;
  logic [dbtd_pkg::DIVIDEND_W-1:0]   dividend;
  logic                              div_start;
  dbtd_pkg::div_stat_t               div_stat;

  assign run_level = s_tdata[0];
  assign run_ticks = s_tdata[15:1];
  assign s_tready  = (state == S_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign div_start = in_xfer && (run_ticks != '0);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == dbtd_pkg::ADDR_BIT_PERIOD) ?
                  32'(bit_period_ns) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period_ns <= dbtd_pkg::PERIOD_RESET;
    end else if (cfg_wr && paddr == dbtd_pkg::ADDR_BIT_PERIOD) begin
      bit_period_ns <= pwdata[dbtd_pkg::PERIOD_W-1:0];
    end
  end

  // round(ticks * 100 / period): add half the period before dividing
  always_comb begin
    period_eff  = (bit_period_ns == '0) ? dbtd_pkg::PERIOD_W'(1) : bit_period_ns;
    dividend    = dbtd_pkg::DIVIDEND_W'(run_ticks) *
                  dbtd_pkg::DIVIDEND_W'(dbtd_pkg::TICK_NS) +
                  dbtd_pkg::DIVIDEND_W'(period_eff >> 1);
    start_ok_in = (run_index == '0) ? (!run_level && run_ticks != '0) : start_ok;
  end

  dbtd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (period_eff),
    .stat     (div_stat)
  );

  // shift the run's bits into the frame register
  logic [dbtd_pkg::QUOT_W-1:0]       nbits;
  logic [4:0]                        nsh;
  logic [dbtd_pkg::FRAME_BITS-1:0]   shift_next;
  logic [dbtd_pkg::TOTAL_W:0]        total_sum;
  logic [dbtd_pkg::TOTAL_W-1:0]      total_next;
  logic [IDX_W-1:0]                  index_next;

  always_comb begin
    nbits     = div_stat.quotient;
    nsh       = nbits[4:0];
    total_sum = {1'b0, bit_total} + (dbtd_pkg::TOTAL_W + 1)'(nsh);
    if (nbits >= dbtd_pkg::QUOT_W'(dbtd_pkg::FRAME_BITS)) begin
      shift_next = run_level_q ? ONES : '0;
    end else begin
      shift_next = (bit_shift_reg << nsh) | (run_level_q ? ~(ONES << nsh) : '0);
    end
    if (nbits >= dbtd_pkg::QUOT_W'(dbtd_pkg::TOTAL_SAT) ||
        total_sum > (dbtd_pkg::TOTAL_W + 1)'(dbtd_pkg::TOTAL_SAT)) begin
      total_next = dbtd_pkg::TOTAL_W'(dbtd_pkg::TOTAL_SAT);
    end else begin
      total_next = total_sum[dbtd_pkg::TOTAL_W-1:0];
    end
    index_next = run_index + 1'b1;
  end

  // pad with ones, undo the transition coding, map GCR codes
  logic [4:0]                        pad;
  logic [dbtd_pkg::FRAME_BITS-1:0]   padded;
  logic [dbtd_pkg::FRAME_BITS-1:0]   plain;
  logic [dbtd_pkg::CODE_W-1:0]       code_next;

  always_comb begin
    pad       = 5'(dbtd_pkg::FRAME_BITS) - bit_total;
    padded    = (bit_shift_reg << pad) | ~(ONES << pad);
    plain     = padded ^ (padded >> 1);
    code_next = '0;
    for (int i = 0; i < 4; i++) begin
      code_next = code_next |
                  dbtd_pkg::CODE_W'({8'h00, dbtd_pkg::gcr_decode(plain[5*i +: 5])} << (4*i));
    end
  end

  // CRC check and report fields
  logic [3:0]                        crc;
  logic                              crc_ok;
  logic [dbtd_pkg::PAYLOAD_W-1:0]    payload;
  logic [dbtd_pkg::ERPM_W-1:0]       erpm;
  logic                              out_free;
  logic                              report_fire;
  dbtd_pkg::status_t                 rep_status;
  logic [dbtd_pkg::PAYLOAD_W-1:0]    rep_payload;
  logic [dbtd_pkg::ERPM_W-1:0]       rep_erpm;
  logic [2:0]                        rep_type;
  logic [7:0]                        rep_value;
  logic [dbtd_pkg::CNT_W-1:0]        seen_next;
  logic [dbtd_pkg::CNT_W-1:0]        good_next;

  always_comb begin
    crc         = ~(code_word[7:4] ^ code_word[11:8] ^ code_word[15:12]);
    crc_ok      = (crc == code_word[3:0]);
    payload     = code_word[15:4];
    erpm        = (payload == dbtd_pkg::PAYLOAD_NONE) ? '0 :
                  (dbtd_pkg::ERPM_W'(payload[8:0]) << payload[11:9]);
    out_free    = !m_tvalid || m_tready;
    report_fire = (state == S_REPORT) && out_free;
    rep_status  = frame_kind;
    rep_payload = '0;
    rep_erpm    = '0;
    rep_type    = '0;
    rep_value   = '0;
    seen_next   = seen_counter;
    good_next   = good_counter;
    if (frame_kind != dbtd_pkg::ST_BAD_START) begin
      seen_next = seen_counter + 1'b1;
    end
    if (frame_kind == dbtd_pkg::ST_BAD_CRC && crc_ok) begin
      good_next   = good_counter + 1'b1;
      rep_payload = payload;
      if (payload[8]) begin
        rep_status = dbtd_pkg::ST_ERPM;
        rep_erpm   = erpm;
      end else begin
        rep_status = dbtd_pkg::ST_TELEM;
        rep_type   = payload[11:9];
        rep_value  = payload[7:0];
      end
    end
  end

  // sequencer, frame state, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bit_shift_reg <= '0;
      bit_total     <= '0;
      run_index     <= '0;
      start_ok      <= 1'b0;
      seen_counter  <= '0;
      good_counter  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // raise valid on a new report, drop it once the transfer is taken
      if (report_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            start_ok    <= start_ok_in;
            run_level_q <= run_level;
            state       <= (run_ticks == '0) ? S_DECODE : S_DIV;
          end
        end
        S_DIV: begin
          // apply once the divider has finished
          if (!div_stat.busy) begin
            bit_shift_reg <= shift_next;
            bit_total     <= total_next;
            run_index     <= index_next;
            state         <= (index_next >= IDX_W'(MAX_RUNS)) ? S_DECODE : S_IDLE;
          end
        end
        S_DECODE: begin
          code_word <= code_next;
          if (!start_ok) begin
            frame_kind <= dbtd_pkg::ST_BAD_START;
          end else if (bit_total > dbtd_pkg::TOTAL_W'(dbtd_pkg::FRAME_BITS)) begin
            frame_kind <= dbtd_pkg::ST_TOO_LONG;
          end else begin
            frame_kind <= dbtd_pkg::ST_BAD_CRC;
          end
          state <= S_REPORT;
        end
        S_REPORT: begin
          // hold until the output register is free
          if (out_free) begin
            out_status    <= rep_status;
            out_payload   <= rep_payload;
            out_erpm      <= rep_erpm;
            out_type      <= rep_type;
            out_value     <= rep_value;
            seen_counter  <= seen_next;
            good_counter  <= good_next;
            out_seen      <= seen_next;
            out_good      <= good_next;
            bit_shift_reg <= '0;
            bit_total     <= '0;
            run_index     <= '0;
            start_ok      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {1'b0, out_good, out_seen, out_value, out_type, out_erpm, out_payload};

  // the divider is never running while a new run can be taken
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_stat.busy)
    else $error("divider busy while accepting a run");

  // the good-frame count only moves together with the seen count
  a_good_seen: assert property (@(posedge clk) disable iff (rst)
    (good_counter != $past(good_counter)) |-> (seen_counter != $past(seen_counter)))
    else $error("good frame counted without a seen frame");

  // the bit total saturates
  a_total_sat: assert property (@(posedge clk) disable iff (rst)
    bit_total <= dbtd_pkg::TOTAL_W'(dbtd_pkg::TOTAL_SAT))
    else $error("bit total above saturation");

  // a frame never waits for input with a full run count
  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (run_index < IDX_W'(MAX_RUNS)))
    else $error("run count reached the limit while idle");

endmodule

// ----- dv/dshot_bidir_telemetry_decoder_top_tb.sv -----
// Self-checking testbench for dshot_bidir_telemetry_decoder_top: GCR-encoded frames,
// noise, runaway frames and period changes, each report checked against a predictor.
// Depends on dbtd_pkg and the decoder RTL.
module dshot_bidir_telemetry_decoder_top_tb;

  localparam int RUNS_PER_FRAME = 42;
  localparam int SETTLE_CYCLES  = 40;
  localparam int STALL_LIMIT    = 2000;

  // one decoded frame report as the block presents it
  typedef struct {
    dbtd_pkg::status_t status;
    logic [11:0]       payload;
    logic [15:0]       erpm;
    logic [2:0]        slot;
    logic [7:0]        value;
    logic [31:0]       seen;
    logic [31:0]       good;
  } frame_report_t;

  // Predicts frame reports from accepted runs and checks the block's reports.
  class frame_scoreboard;
    int unsigned   max_runs;
    logic [12:0]   period;
    logic [31:0]   shift_bits;
    int unsigned   bit_count;
    int unsigned   run_count;
    bit            start_good;
    logic [31:0]   seen_total;
    logic [31:0]   good_total;
    frame_report_t expected_q[$];
    int unsigned   errors;

    function new(int unsigned runs_per_frame);
      max_runs   = runs_per_frame;
      period     = dbtd_pkg::PERIOD_RESET;
      seen_total = '0;
      good_total = '0;
      errors     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      shift_bits = '0;
      bit_count  = 0;
      run_count  = 0;
      start_good = 1'b0;
    endfunction

    // nibble to 5-bit GCR code
    function logic [4:0] gcr_code(input logic [3:0] nib);
      logic [4:0] code;
      case (nib)
        4'h0: code = 5'h19;
        4'h1: code = 5'h1B;
        4'h2: code = 5'h12;
        4'h3: code = 5'h13;
        4'h4: code = 5'h1D;
        4'h5: code = 5'h15;
        4'h6: code = 5'h16;
        4'h7: code = 5'h17;
        4'h8: code = 5'h1A;
        4'h9: code = 5'h09;
        4'hA: code = 5'h0A;
        4'hB: code = 5'h0B;
        4'hC: code = 5'h1E;
        4'hD: code = 5'h0D;
        4'hE: code = 5'h0E;
        default: code = 5'h0F;
      endcase
      return code;
    endfunction

    // invert the code table; anything not in it reads as 0xFF
    function logic [7:0] gcr_nibble(input logic [4:0] code);
      int n;
      for (n = 0; n < 16; n++) begin
        if (gcr_code(4'(n)) == code) return 8'(n);
      end
      return 8'hFF;
    endfunction

    function void close_frame();
      frame_report_t r;
      int unsigned   pad;
      logic [31:0]   line_bits;
      logic [31:0]   nrz;
      logic [31:0]   word;
      logic [3:0]    crc;
      logic [11:0]   p;
      int            i;
      r.status  = dbtd_pkg::ST_BAD_START;
      r.payload = '0;
      r.erpm    = '0;
      r.slot    = '0;
      r.value   = '0;
      if (start_good) begin
        seen_total++;
        if (bit_count > dbtd_pkg::FRAME_BITS) begin
          r.status = dbtd_pkg::ST_TOO_LONG;
        end else begin
          // pad with idle-high bits, undo the transition coding, map the codes
          pad       = dbtd_pkg::FRAME_BITS - bit_count;
          line_bits = ((shift_bits << pad) | ((32'd1 << pad) - 32'd1)) & 32'h1F_FFFF;
          nrz       = line_bits ^ (line_bits >> 1);
          word      = '0;
          for (i = 0; i < 4; i++) begin
            word = word | (32'(gcr_nibble(5'((nrz >> (5 * i)) & 32'h1F))) << (4 * i));
          end
          word = word & 32'hFFFF;
          crc  = ~(word[7:4] ^ word[11:8] ^ word[15:12]);
          if (crc != word[3:0]) begin
            r.status = dbtd_pkg::ST_BAD_CRC;
          end else begin
            good_total++;
            p         = word[15:4];
            r.payload = p;
            if (p[8]) begin
              r.status = dbtd_pkg::ST_ERPM;
              r.erpm   = (p == 12'hFFF) ? 16'h0 : 16'((32'(p[8:0]) << p[11:9]) & 32'hFFFF);
            end else begin
              r.status = dbtd_pkg::ST_TELEM;
              r.slot   = p[11:9];
              r.value  = p[7:0];
            end
          end
        end
      end
      r.seen = seen_total;
      r.good = good_total;
      expected_q.push_back(r);
      clear_frame();
    endfunction

    // note one accepted run and predict the report it closes, if any
    function void note_run(input logic level, input logic [14:0] ticks);
      int unsigned div;
      int unsigned bits;
      if (run_count == 0) start_good = (level == 1'b0) && (ticks != 0);
      if (ticks == 0) begin
        close_frame();
      end else begin
        div       = (period == 0) ? 1 : int'(period);
        bits      = (32'(ticks) * 100 + div / 2) / div;
        bit_count = (bit_count + bits > dbtd_pkg::TOTAL_SAT) ? dbtd_pkg::TOTAL_SAT :
                    bit_count + bits;
        if (bits >= dbtd_pkg::FRAME_BITS) begin
          shift_bits = level ? 32'h1F_FFFF : 32'h0;
        end else if (bits > 0) begin
          shift_bits = ((shift_bits << bits) | (level ? ((32'd1 << bits) - 32'd1) : 32'd0))
                       & 32'h1F_FFFF;
        end
        run_count++;
        if (run_count >= max_runs) close_frame();
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(input logic [103:0] data, input logic [2:0] user);
      frame_report_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected report: expected none, actual status %0d data %h",
                 $time, user, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", 32'(e.status), 32'(user));
      compare_field("raw_payload", 32'(e.payload), 32'(data[11:0]));
      compare_field("erpm_period_us", 32'(e.erpm), 32'(data[27:12]));
      compare_field("telem_type", 32'(e.slot), 32'(data[30:28]));
      compare_field("telem_value", 32'(e.value), 32'(data[38:31]));
      compare_field("frames_seen", e.seen, data[70:39]);
      compare_field("frames_good", e.good, data[102:71]);
    endfunction
  endclass

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata  = '0;   // [0] run_level, [15:1] run_ticks
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;         // [11:0] raw_payload, [27:12] erpm_period_us,
                                 // [30:28] telem_type, [38:31] telem_value,
                                 // [70:39] frames_seen, [102:71] frames_good
  logic [2:0]   m_tuser;         // [2:0] status
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [2:0]   paddr    = '0;
  logic [31:0]  pwdata   = '0;
  logic [31:0]  prdata;
  logic         pready;

  frame_scoreboard sb = new(RUNS_PER_FRAME);
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     runs_sent     = 0;
  int unsigned     quiet_cycles  = 0;
  logic [12:0]     cur_period    = dbtd_pkg::PERIOD_RESET;

  dshot_bidir_telemetry_decoder_top #(
    .MAX_RUNS(RUNS_PER_FRAME)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // stall the report side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // check reports, note runs, and watch for a hung block
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_report(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_run(s_tdata[0], s_tdata[15:1]);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // run length in ticks for a bit count, with up to a quarter bit of jitter
  function automatic int bits_to_ticks(int n);
    int div;
    int jit;
    int t;
    div = (cur_period == 0) ? 1 : int'(cur_period);
    jit = div / 400;
    t   = (n * div + 50) / 100 + int'($urandom_range(2 * jit)) - jit;
    if (t < 1) t = 1;
    if (t > 32767) t = 32767;
    return t;
  endfunction

  function automatic logic [11:0] pick_payload();
    logic [11:0] p;
    if ($urandom_range(9) != 0) begin
      p = 12'($urandom_range(4095));
    end else begin
      case ($urandom_range(5))
        0: p = 12'h000;
        1: p = 12'hFFF;
        2: p = 12'hFFE;
        3: p = 12'hEFF;
        4: p = 12'h100;
        default: p = 12'h0FF;
      endcase
    end
    return p;
  endfunction

  // present one run and hold it until the transfer
  task automatic send_run(input logic level, input int ticks);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {15'(ticks), level};
    do @(posedge clk); while (!s_tready);
    runs_sent++;
  endtask

  // encode a payload as a line frame; optionally drop the idle tail or damage a run
  task automatic send_frame(input logic [11:0] payload, input bit drop_tail, input bit damage);
    logic [15:0] word;
    logic [19:0] codes;
    logic [20:0] line_bits;
    int          lens [21];
    bit          lvls [21];
    int          count;
    int          k;
    int          i;
    word  = {payload, ~(payload[3:0] ^ payload[7:4] ^ payload[11:8])};
    codes = {sb.gcr_code(word[15:12]), sb.gcr_code(word[11:8]),
             sb.gcr_code(word[7:4]), sb.gcr_code(word[3:0])};
    line_bits[20] = 1'b0;
    for (i = 19; i >= 0; i--) line_bits[i] = codes[i] ^ line_bits[i + 1];
    count = 0;
    for (i = 20; i >= 0; i--) begin
      if (count > 0 && lvls[count - 1] == line_bits[i]) begin
        lens[count - 1]++;
      end else begin
        lvls[count] = line_bits[i];
        lens[count] = 1;
        count++;
      end
    end
    if (drop_tail && count > 1 && lvls[count - 1]) count--;
    if (damage) begin
      k = $urandom_range(count - 1);
      if ($urandom_range(1) != 0 && lens[k] > 1) lens[k]--;
      else lens[k]++;
    end
    for (i = 0; i < count; i++) send_run(lvls[i], bits_to_ticks(lens[i]));
    send_run(1'($urandom_range(1)), 0);
  endtask

  // random levels and lengths, closed by an end marker
  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(1, 12);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_run(1'($urandom_range(1)), $urandom_range(1, 32767));
      else send_run(1'($urandom_range(1)), bits_to_ticks($urandom_range(1, 6)));
    end
    send_run(1'($urandom_range(1)), 0);
  endtask

  // hit the run limit with mostly sub-bit runs
  task automatic send_long_frame();
    int i;
    for (i = 0; i < RUNS_PER_FRAME; i++) begin
      if ($urandom_range(7) == 0) send_run(1'(i % 2), bits_to_ticks(1));
      else send_run(1'(i % 2), $urandom_range(1, 3));
    end
  endtask

  // lower valid, wait for every report, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [12:0] period);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dbtd_pkg::ADDR_BIT_PERIOD;
    pwdata  <= {19'd0, period};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.period  = period;
    cur_period = period;
  endtask

  task automatic run_mix(input int unsigned target);
    int unsigned first;
    int unsigned pick;
    first = runs_sent;
    while (runs_sent - first < target) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        send_frame(pick_payload(), 1'($urandom_range(1)), 1'b0);
      end else if (pick < 72) begin
        send_frame(pick_payload(), 1'($urandom_range(1)), 1'b1);
      end else if (pick < 77) begin
        // high first run spoils the start
        send_run(1'b1, bits_to_ticks($urandom_range(1, 3)));
        send_frame(pick_payload(), 1'b0, 1'b0);
      end else if (pick < 89) begin
        send_noise();
      end else if (pick < 95) begin
        send_long_frame();
      end else begin
        send_run(1'($urandom_range(1)), 0);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: bad starts, huge runs, a full-length frame at the reset period
    send_idle_pct = 6;
    recv_idle_pct = 73;
    send_run(1'b0, 0);
    send_run(1'b1, 32767);
    send_run(1'b0, 0);
    send_run(1'b0, 32767);
    send_run(1'b1, 0);
    send_frame(12'hFFF, 1'b0, 1'b0);
    send_frame(12'hFFE, 1'b1, 1'b0);

    drain();
    write_period(13'd2666);
    run_mix(400);
    drain();
    write_period(13'd667);
    run_mix(400);

    send_idle_pct = 73;
    recv_idle_pct = 6;
    drain();
    write_period(13'd5333);
    run_mix(400);
    drain();
    write_period(13'd8191);
    run_mix(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    write_period(13'd0);
    run_mix(80);
    drain();
    write_period(13'($urandom_range(667, 5333)));
    run_mix(350);

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- dshot_bidir_telemetry_decoder_top.f -----
rtl/core/dbtd_pkg.sv
rtl/core/dbtd_div.sv
rtl/core/dshot_bidir_telemetry_decoder_top.sv
dv/dshot_bidir_telemetry_decoder_top_tb.sv
